>>> hdl/hbd_pkg.sv
// Shared constants, region codes and controller command type for the bus decoder.
package hbd_pkg;

    localparam int ROM_BANK_BYTES     = 16384;
    localparam int EXT_RAM_BYTES      = 32768;
    localparam int EXT_RAM_BANK_BYTES = 8192;
    localparam int MAX_ROM_BANKS      = 512;

    localparam int COUNT_W  = 10;
    localparam int SIZE_W   = 24;
    localparam int OFFSET_W = 23;
    localparam int BANK_W   = 9;
    localparam int DIVD_W   = 8;
    localparam int CFG_IDX_W = 8;

    typedef logic [3:0] region_t;

    localparam region_t R_ROM    = 4'd0;
    localparam region_t R_VRAM   = 4'd1;
    localparam region_t R_EXTRAM = 4'd2;
    localparam region_t R_WRAM0  = 4'd3;
    localparam region_t R_WRAM1  = 4'd4;
    localparam region_t R_OAM    = 4'd5;
    localparam region_t R_IO     = 4'd6;
    localparam region_t R_HRAM   = 4'd7;
    localparam region_t R_IE     = 4'd8;
    localparam region_t R_NONE   = 4'd9;

    localparam logic [CFG_IDX_W-1:0] CFG_MBC3_MODE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BANK_COUNT = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROM_SIZE   = 8'd3;

    localparam logic [15:0] VBK_ADDR = 16'hFF4F;

    typedef struct packed {
        logic load_in;
        logic div_step;
        logic finish;
    } hbd_cmd_t;

endpackage

>>> hdl/handheld_bus_decoder_with_mbc3_banking.sv
// Top level of the handheld bus decoder with MBC3 cartridge banking.
//
// The input channel carries one CPU bus access per transfer: op, bus_address and
// write_value, qualified by in_valid and held off by in_stall. The output channel
// carries one decoded result per access on region, offset, fixed_read, fixed_value,
// store_enable and write_data, qualified by out_valid and held off by out_stall.
// Configuration registers are written over cfg_valid, cfg_ready, cfg_index and
// cfg_data; the user must write them only while the block is idle, which the block
// itself does not enforce; cfg_ready is always high.
// After the input transfer, the bank modulo divider resolves two quotient bits per cycle
// and the result is then loaded into the result register. A new access is accepted again
// in the cycle after the result is loaded, so the block takes no new access before then.
// When the receiver stalls, the finished result stays in the output register and
// the block may accept and compute the next access, then waits until the
// register is free. Reset clears the configuration to zero, selects ROM bank 1,
// RAM bank 0 and video bank 0, disables cartridge RAM and empties the output.
module handheld_bus_decoder_with_mbc3_banking #(
    parameter int MAX_ROM_BANKS = hbd_pkg::MAX_ROM_BANKS,
    parameter int EXT_RAM_BYTES = hbd_pkg::EXT_RAM_BYTES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          op,
    input  logic [15:0]                   bus_address,
    input  logic [7:0]                    write_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [3:0]                    region,
    output logic [hbd_pkg::OFFSET_W-1:0]  offset,
    output logic                          fixed_read,
    output logic [7:0]                    fixed_value,
    output logic                          store_enable,
    output logic [7:0]                    write_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hbd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hbd_pkg::SIZE_W-1:0]    cfg_data
);

    hbd_pkg::hbd_cmd_t cmd;

    assign cfg_ready = 1'b1;

    hbd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    hbd_datapath #(
        .MAX_ROM_BANKS (MAX_ROM_BANKS),
        .EXT_RAM_BYTES (EXT_RAM_BYTES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_write    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .op           (op),
        .bus_address  (bus_address),
        .write_value  (write_value),
        .region       (region),
        .offset       (offset),
        .fixed_read   (fixed_read),
        .fixed_value  (fixed_value),
        .store_enable (store_enable),
        .write_data   (write_data)
    );

endmodule

>>> hdl/hbd_ctrl.sv
// Controller state machine that sequences accept, bank modulo steps and result transfer.
module hbd_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    output hbd_pkg::hbd_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [1:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    step_next   = 2'd0;
                    state_next  = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hdl/hbd_datapath.sv
// Datapath with configuration, bank state, bank modulo divider, decoder and result registers.
module hbd_datapath #(
    parameter int MAX_ROM_BANKS = hbd_pkg::MAX_ROM_BANKS,
    parameter int EXT_RAM_BYTES = hbd_pkg::EXT_RAM_BYTES
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  hbd_pkg::hbd_cmd_t                  cmd,
    input  logic                               cfg_write,
    input  logic [hbd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hbd_pkg::SIZE_W-1:0]         cfg_data,
    input  logic                               op,
    input  logic [15:0]                        bus_address,
    input  logic [7:0]                         write_value,
    output hbd_pkg::region_t                   region,
    output logic [hbd_pkg::OFFSET_W-1:0]       offset,
    output logic                               fixed_read,
    output logic [7:0]                         fixed_value,
    output logic                               store_enable,
    output logic [7:0]                         write_data
);

    localparam int CW = hbd_pkg::COUNT_W;
    localparam int OW = hbd_pkg::OFFSET_W;
    localparam int BW = hbd_pkg::BANK_W;
    localparam int DW = hbd_pkg::DIVD_W;
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_ROM_BANKS);
    localparam logic [16:0] EXT_LIMIT = 17'(EXT_RAM_BYTES);
    localparam logic [16:0] EXT_BANK = 17'(hbd_pkg::EXT_RAM_BANK_BYTES);

    logic                      mbc3_mode_reg;
    logic                      color_mode_reg;
    logic [CW-1:0]             bank_count_reg;
    logic [hbd_pkg::SIZE_W-1:0] rom_size_reg;

    logic       extram_en_reg, extram_en_next;
    logic [6:0] rom_sel_reg, rom_sel_next;
    logic [1:0] ram_sel_reg, ram_sel_next;
    logic       vbank_reg, vbank_next;

    logic        op_reg;
    logic [15:0] addr_reg;
    logic [7:0]  wval_reg;

    logic [CW-1:0] rem_reg, rem_next;
    logic [DW-1:0] divd_reg, divd_next;

    hbd_pkg::region_t     region_reg, region_next;
    logic [OW-1:0]        offset_reg, offset_next;
    logic                 fixed_reg, fixed_next;
    logic [7:0]           fval_reg, fval_next;
    logic                 store_reg, store_next;
    logic [7:0]           wdata_reg, wdata_next;

    logic [CW-1:0] count;
    logic [CW-1:0] r1, r2;
    logic [BW-1:0] mbc_bank, rom_bank;
    logic [16:0]   ext_off;

    assign count = (bank_count_reg > MAX_COUNT) ? MAX_COUNT : bank_count_reg;

    // Restoring division of the bank select by the bank count, two quotient bits per step.
    always_comb
    begin
        r1 = {rem_reg[CW-2:0], divd_reg[DW-1]};
        if (r1 >= count)
        begin
            r1 = r1 - count;
        end
        r2 = {r1[CW-2:0], divd_reg[DW-2]};
        if (r2 >= count)
        begin
            r2 = r2 - count;
        end
        rem_next  = rem_reg;
        divd_next = divd_reg;
        if (cmd.load_in)
        begin
            rem_next  = '0;
            divd_next = {{(DW-7){1'b0}}, rom_sel_reg};
        end
        else if (cmd.div_step)
        begin
            rem_next  = r2;
            divd_next = {divd_reg[DW-3:0], 2'b00};
        end
    end

    always_comb
    begin
        if (rem_reg == '0)
        begin
            mbc_bank = (count == CW'(1)) ? '0 : BW'(1);
        end
        else
        begin
            mbc_bank = rem_reg[BW-1:0];
        end
        if (count == '0 || addr_reg < 16'h4000)
        begin
            rom_bank = '0;
        end
        else if (mbc3_mode_reg)
        begin
            rom_bank = mbc_bank;
        end
        else
        begin
            rom_bank = (count <= CW'(1)) ? '0 : BW'(1);
        end
        ext_off = {15'd0, ram_sel_reg} * EXT_BANK + {4'd0, addr_reg[12:0]};
    end

    always_comb
    begin
        region_next    = hbd_pkg::R_NONE;
        offset_next    = '0;
        fixed_next     = 1'b0;
        fval_next      = 8'h00;
        store_next     = 1'b0;
        extram_en_next = extram_en_reg;
        rom_sel_next   = rom_sel_reg;
        ram_sel_next   = ram_sel_reg;
        vbank_next     = vbank_reg;

        if (addr_reg < 16'h8000)
        begin
            region_next = hbd_pkg::R_ROM;
            offset_next = {rom_bank, addr_reg[13:0]};
            if ({1'b0, offset_next} >= rom_size_reg)
            begin
                fixed_next = 1'b1;
                fval_next  = 8'hFF;
            end
            if (op_reg && mbc3_mode_reg)
            begin
                if (addr_reg < 16'h2000)
                begin
                    extram_en_next = (wval_reg[3:0] == 4'hA);
                end
                else if (addr_reg < 16'h4000)
                begin
                    rom_sel_next = (wval_reg[6:0] == 7'd0) ? 7'd1 : wval_reg[6:0];
                end
                else if (addr_reg < 16'h6000)
                begin
                    ram_sel_next = wval_reg[1:0];
                end
            end
        end
        else if (addr_reg < 16'hA000)
        begin
            region_next = hbd_pkg::R_VRAM;
            offset_next = OW'({vbank_reg & color_mode_reg, addr_reg[12:0]});
            store_next  = 1'b1;
        end
        else if (addr_reg < 16'hC000)
        begin
            region_next = hbd_pkg::R_EXTRAM;
            offset_next = OW'(ext_off);
            if (extram_en_reg && ext_off < EXT_LIMIT)
            begin
                store_next = 1'b1;
            end
            else
            begin
                fixed_next = 1'b1;
                fval_next  = 8'hFF;
            end
        end
        else if (addr_reg < 16'hFE00)
        begin
            region_next = addr_reg[12] ? hbd_pkg::R_WRAM1 : hbd_pkg::R_WRAM0;
            offset_next = OW'(addr_reg[11:0]);
            store_next  = 1'b1;
        end
        else if (addr_reg < 16'hFEA0)
        begin
            region_next = hbd_pkg::R_OAM;
            offset_next = OW'(addr_reg[7:0]);
            store_next  = 1'b1;
        end
        else if (addr_reg < 16'hFF00)
        begin
            region_next = hbd_pkg::R_NONE;
            fixed_next  = 1'b1;
            fval_next   = 8'h00;
        end
        else if (addr_reg < 16'hFF80)
        begin
            region_next = hbd_pkg::R_IO;
            offset_next = OW'(addr_reg[6:0]);
            store_next  = 1'b1;
            if (addr_reg == hbd_pkg::VBK_ADDR)
            begin
                fixed_next = 1'b1;
                fval_next  = {7'd0, vbank_reg};
                if (op_reg)
                begin
                    vbank_next = wval_reg[0];
                end
            end
        end
        else if (addr_reg < 16'hFFFF)
        begin
            region_next = hbd_pkg::R_HRAM;
            offset_next = OW'(addr_reg[6:0]);
            store_next  = 1'b1;
        end
        else
        begin
            region_next = hbd_pkg::R_IE;
            store_next  = 1'b1;
        end

        if (op_reg)
        begin
            fixed_next = 1'b0;
            fval_next  = 8'h00;
        end
        else
        begin
            store_next = 1'b0;
        end
        wdata_next = store_next ? wval_reg : 8'h00;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbc3_mode_reg  <= 1'b0;
            color_mode_reg <= 1'b0;
            bank_count_reg <= '0;
            rom_size_reg   <= '0;
            extram_en_reg  <= 1'b0;
            rom_sel_reg    <= 7'd1;
            ram_sel_reg    <= 2'd0;
            vbank_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    hbd_pkg::CFG_MBC3_MODE:  mbc3_mode_reg  <= cfg_data[0];
                    hbd_pkg::CFG_COLOR_MODE: color_mode_reg <= cfg_data[0];
                    hbd_pkg::CFG_BANK_COUNT: bank_count_reg <= cfg_data[CW-1:0];
                    hbd_pkg::CFG_ROM_SIZE:   rom_size_reg   <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.finish)
            begin
                extram_en_reg <= extram_en_next;
                rom_sel_reg   <= rom_sel_next;
                ram_sel_reg   <= ram_sel_next;
                vbank_reg     <= vbank_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg   <= op;
            addr_reg <= bus_address;
            wval_reg <= write_value;
        end
        rem_reg  <= rem_next;
        divd_reg <= divd_next;
        if (cmd.finish)
        begin
            region_reg <= region_next;
            offset_reg <= offset_next;
            fixed_reg  <= fixed_next;
            fval_reg   <= fval_next;
            store_reg  <= store_next;
            wdata_reg  <= wdata_next;
        end
    end

    assign region       = region_reg;
    assign offset       = offset_reg;
    assign fixed_read   = fixed_reg;
    assign fixed_value  = fval_reg;
    assign store_enable = store_reg;
    assign write_data   = wdata_reg;

endmodule
